FILE: hw/rtl/amd_pkg.sv
// Package for the affine matrix decompose unit: pipeline depths, fixed-point types
// and the per-stage step functions (square root, division, CORDIC vectoring).
// Depends on nothing; imported by affine_matrix_decompose_unit.
`default_nettype none
package amd_pkg;

  localparam int SQ_N   = 32;
  localparam int SQ_TOP = 62;
  localparam int DV_N   = 17;
  localparam int CY_N   = 17;
  localparam int CY_TOP = 32;
  localparam int CR_N   = 16;
  localparam int NDIV   = 7;
  localparam int CW     = 40;
  localparam int ZW     = 21;
  localparam int AW     = 19;

  localparam logic signed [ZW-1:0] HALF_PI   = 21'sd102944;
  localparam logic signed [ZW-1:0] ANGLE_MAX = 21'sd205888;

  typedef logic signed [31:0] elem_t;

  typedef struct packed {
    logic [8:0][31:0] m;
    logic [2:0][31:0] tr;
  } mat_t;

  typedef struct packed {
    logic [2:0][31:0] tr;
    logic [2:0][31:0] s;
    logic             dg;
  } side_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [48:0] rem;
    logic [16:0] q;
  } dv_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cr_t;

  // quotient lanes: r00 r01 r10 r11 r20 r21 r22
  function automatic int div_src(input int j);
    int o;
    unique case (j)
      0: o = 0;
      1: o = 1;
      2: o = 3;
      3: o = 4;
      4: o = 6;
      5: o = 7;
      default: o = 8;
    endcase
    return o;
  endfunction

  function automatic int div_row(input int j);
    int o;
    if (j < 2) o = 0;
    else if (j < 4) o = 1;
    else o = 2;
    return o;
  endfunction

  function automatic logic signed [ZW-1:0] atan_q(input int i);
    logic signed [ZW-1:0] o;
    unique case (i)
      0: o = 21'sd51472;
      1: o = 21'sd30386;
      2: o = 21'sd16055;
      3: o = 21'sd8150;
      4: o = 21'sd4091;
      5: o = 21'sd2047;
      6: o = 21'sd1024;
      7: o = 21'sd512;
      8: o = 21'sd256;
      9: o = 21'sd128;
      10: o = 21'sd64;
      11: o = 21'sd32;
      12: o = 21'sd16;
      13: o = 21'sd8;
      14: o = 21'sd4;
      15: o = 21'sd2;
      default: o = '0;
    endcase
    return o;
  endfunction

  function automatic sq_t sqrt_step(input sq_t a, input int sh);
    logic [63:0] b;
    logic [63:0] t;
    sq_t o;
    b = 64'd1 << sh;
    t = a.r + b;
    if (a.n >= t) begin
      o.n = a.n - t;
      o.r = (a.r >> 1) + b;
    end else begin
      o.n = a.n;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  function automatic dv_t div_init(input logic [31:0] mv);
    logic [31:0] mag;
    dv_t o;
    mag = mv[31] ? (~mv + 32'd1) : mv;
    o.rem = {1'b0, mag, 16'd0};
    o.q = '0;
    return o;
  endfunction

  function automatic dv_t div_step(input dv_t a, input logic [31:0] s, input int k);
    logic [48:0] d;
    dv_t o;
    d = 49'(s) << k;
    o = a;
    if (a.rem >= d) begin
      o.rem = a.rem - d;
      o.q[k] = 1'b1;
    end
    return o;
  endfunction

  function automatic cr_t cr_init(input logic signed [AW-1:0] yi,
                                  input logic signed [AW-1:0] xi);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    cr_t o;
    xs = CW'(xi) <<< 16;
    ys = CW'(yi) <<< 16;
    if (xs < 0) begin
      if (ys >= 0) begin
        o.x = ys;
        o.y = -xs;
        o.z = HALF_PI;
      end else begin
        o.x = -ys;
        o.y = xs;
        o.z = -HALF_PI;
      end
    end else begin
      o.x = xs;
      o.y = ys;
      o.z = '0;
    end
    return o;
  endfunction

  function automatic cr_t cr_step(input cr_t a, input int i);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    cr_t o;
    xs = a.x >>> i;
    ys = a.y >>> i;
    if (a.y > 0) begin
      o.x = a.x + ys;
      o.y = a.y - xs;
      o.z = a.z + atan_q(i);
    end else begin
      o.x = a.x - ys;
      o.y = a.y + xs;
      o.z = a.z - atan_q(i);
    end
    return o;
  endfunction

  function automatic logic signed [AW-1:0] clamp_angle(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] c;
    c = z;
    if (z > ANGLE_MAX) c = ANGLE_MAX;
    if (z < -ANGLE_MAX) c = -ANGLE_MAX;
    return c[AW-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/affine_matrix_decompose_unit.sv
// Affine matrix decompose unit: position, row scales and Euler angles per matrix.
// Depends on amd_pkg for types, constants and the step functions.
//
// One matrix enters per cycle while out_stall does not hold the pipeline; the depth is
// set by the 32-step row-length square root, the 17-step restoring dividers, the
// 17-step cosine square root and the 16-step CORDIC lanes, one step per stage.
// The whole pipeline holds while a result waits on out_stall.
`default_nettype none
module affine_matrix_decompose_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [16:0]                     cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire amd_pkg::elem_t                  row0_x,
  input  wire amd_pkg::elem_t                  row0_y,
  input  wire amd_pkg::elem_t                  row0_z,
  input  wire amd_pkg::elem_t                  row1_x,
  input  wire amd_pkg::elem_t                  row1_y,
  input  wire amd_pkg::elem_t                  row1_z,
  input  wire amd_pkg::elem_t                  row2_x,
  input  wire amd_pkg::elem_t                  row2_y,
  input  wire amd_pkg::elem_t                  row2_z,
  input  wire amd_pkg::elem_t                  trans_x,
  input  wire amd_pkg::elem_t                  trans_y,
  input  wire amd_pkg::elem_t                  trans_z,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output amd_pkg::elem_t                       pos_x,
  output amd_pkg::elem_t                       pos_y,
  output amd_pkg::elem_t                       pos_z,
  output logic signed [amd_pkg::AW-1:0]        angle_x,
  output logic signed [amd_pkg::AW-1:0]        angle_y,
  output logic signed [amd_pkg::AW-1:0]        angle_z,
  output logic [31:0]                          scale_x,
  output logic [31:0]                          scale_y,
  output logic [31:0]                          scale_z,
  output logic                                 degenerate
);
  import amd_pkg::*;

  localparam int LAT = 2 + SQ_N + DV_N + 1 + CY_N + 1 + CR_N + 1;

  logic [16:0]          thr;
  logic                 adv;
  logic [LAT-1:0]       v;

  elem_t                el [9];
  logic signed [63:0]   sqp [9];
  mat_t                 m1;
  mat_t                 m2;
  logic [63:0]          sq1 [9];
  logic [63:0]          sum2 [3];

  sq_t                  sqs [1:SQ_N][3];
  mat_t                 sqm [1:SQ_N];

  dv_t                  dvs [1:DV_N][NDIV];
  logic [NDIV-1:0]      dneg [1:DV_N];
  side_t                dside [1:DV_N];

  logic signed [AW-1:0] rr [NDIV];
  logic [63:0]          cysq;
  side_t                rside;

  sq_t                  cys [1:CY_N];
  logic signed [AW-1:0] crr [1:CY_N][NDIV];
  side_t                cside [1:CY_N];

  logic [16:0]          cy;
  logic                 gim;
  logic signed [AW-1:0] ly [3];
  logic signed [AW-1:0] lx [3];

  cr_t                  crs [0:CR_N][3];
  logic [2:0]           czf [0:CR_N];
  logic                 cgim [0:CR_N];
  side_t                crside [0:CR_N];

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = v[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= '0;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[LAT-2:0], in_valid};
    end
  end

  assign el[0] = row0_x;
  assign el[1] = row0_y;
  assign el[2] = row0_z;
  assign el[3] = row1_x;
  assign el[4] = row1_y;
  assign el[5] = row1_z;
  assign el[6] = row2_x;
  assign el[7] = row2_y;
  assign el[8] = row2_z;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      sqp[k] = el[k] * el[k];
    end
  end

  // squares, row sums
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 9; k++) begin
        m1.m[k] <= el[k];
        sq1[k]  <= sqp[k];
      end
      m1.tr <= {trans_z, trans_y, trans_x};
      m2    <= m1;
      for (int i = 0; i < 3; i++) begin
        sum2[i] <= sq1[3*i] + sq1[3*i+1] + sq1[3*i+2];
      end
    end
  end

  // row length square root
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sqs[1][i] <= sqrt_step(sq_t'{n: sum2[i], r: 64'd0}, SQ_TOP);
      end
      sqm[1] <= m2;
      for (int st = 2; st <= SQ_N; st++) begin
        for (int i = 0; i < 3; i++) begin
          sqs[st][i] <= sqrt_step(sqs[st-1][i], SQ_TOP - 2*(st-1));
        end
        sqm[st] <= sqm[st-1];
      end
    end
  end

  // restoring dividers, one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NDIV; j++) begin
        dvs[1][j] <= div_step(div_init(sqm[SQ_N].m[div_src(j)]),
                              sqs[SQ_N][div_row(j)].r[31:0], DV_N-1);
        dneg[1][j] <= sqm[SQ_N].m[div_src(j)][31];
      end
      dside[1].tr <= sqm[SQ_N].tr;
      dside[1].s  <= {sqs[SQ_N][2].r[31:0], sqs[SQ_N][1].r[31:0], sqs[SQ_N][0].r[31:0]};
      dside[1].dg <= (sqs[SQ_N][0].r[31:0] == '0) || (sqs[SQ_N][1].r[31:0] == '0) ||
                     (sqs[SQ_N][2].r[31:0] == '0);
      for (int st = 2; st <= DV_N; st++) begin
        for (int j = 0; j < NDIV; j++) begin
          dvs[st][j] <= div_step(dvs[st-1][j], dside[st-1].s[div_row(j)], DV_N-st);
        end
        dneg[st]  <= dneg[st-1];
        dside[st] <= dside[st-1];
      end
    end
  end

  // signed rotation terms, cosine square sum
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NDIV; j++) begin
        rr[j] <= dneg[DV_N][j] ? -$signed({2'b00, dvs[DV_N][j].q})
                               :  $signed({2'b00, dvs[DV_N][j].q});
      end
      cysq  <= 64'(dvs[DV_N][6].q) * 64'(dvs[DV_N][6].q) +
               64'(dvs[DV_N][4].q) * 64'(dvs[DV_N][4].q);
      rside <= dside[DV_N];
    end
  end

  // cosine square root
  always_ff @(posedge clk) begin
    if (adv) begin
      cys[1]   <= sqrt_step(sq_t'{n: cysq, r: 64'd0}, CY_TOP);
      crr[1]   <= rr;
      cside[1] <= rside;
      for (int st = 2; st <= CY_N; st++) begin
        cys[st]   <= sqrt_step(cys[st-1], CY_TOP - 2*(st-1));
        crr[st]   <= crr[st-1];
        cside[st] <= cside[st-1];
      end
    end
  end

  always_comb begin
    cy    = cys[CY_N].r[16:0];
    gim   = (cy <= thr);
    ly[0] = -crr[CY_N][5];
    lx[0] = $signed({2'b00, cy});
    ly[1] = crr[CY_N][4];
    lx[1] = crr[CY_N][6];
    if (gim) begin
      ly[2] = -crr[CY_N][2];
      lx[2] = crr[CY_N][0];
    end else begin
      ly[2] = crr[CY_N][1];
      lx[2] = crr[CY_N][3];
    end
  end

  // CORDIC vectoring lanes
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        crs[0][l]    <= cr_init(ly[l], lx[l]);
        czf[0][l]    <= (ly[l] == '0) && (lx[l] == '0);
      end
      cgim[0]   <= gim;
      crside[0] <= cside[CY_N];
      for (int st = 1; st <= CR_N; st++) begin
        for (int l = 0; l < 3; l++) begin
          crs[st][l] <= cr_step(crs[st-1][l], st-1);
        end
        czf[st]    <= czf[st-1];
        cgim[st]   <= cgim[st-1];
        crside[st] <= crside[st-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x      <= crside[CR_N].tr[0];
      pos_y      <= crside[CR_N].tr[1];
      pos_z      <= crside[CR_N].tr[2];
      scale_x    <= crside[CR_N].s[0];
      scale_y    <= crside[CR_N].s[1];
      scale_z    <= crside[CR_N].s[2];
      degenerate <= crside[CR_N].dg;
      angle_x    <= (crside[CR_N].dg || czf[CR_N][0]) ? '0 : clamp_angle(crs[CR_N][0].z);
      angle_y    <= (crside[CR_N].dg || cgim[CR_N] || czf[CR_N][1]) ? '0
                                                      : clamp_angle(crs[CR_N][1].z);
      angle_z    <= (crside[CR_N].dg || czf[CR_N][2]) ? '0 : clamp_angle(crs[CR_N][2].z);
    end
  end

`ifndef NO_ASSERTIONS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> angle_x == '0 && angle_y == '0 && angle_z == '0)
    else $error("degenerate result carries nonzero angles");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> scale_x != '0 && scale_y != '0 && scale_z != '0)
    else $error("zero scale without degenerate flag");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> angle_x >= -19'sd205888 && angle_x <= 19'sd205888 &&
                  angle_z >= -19'sd205888 && angle_z <= 19'sd205888)
    else $error("angle outside clamp range");
`endif

endmodule
`default_nettype wire
